// ----- design/msort_pkg.sv -----
// ============================================================================
// msort_pkg - shared types and constants of the merge sort engine
// Data width, default capacity, and the command/status bundles that pass
// between the sequencer and the datapath.
// ============================================================================
`timescale 1ns / 1ps

package msort_pkg;

    // element width
    localparam int DATA_W = 32;

    // default number of elements one set may hold
    localparam int CAPACITY_DEF = 64;

    // sequencer -> datapath
    typedef struct packed {
        logic accept_en;   // input side ready, loading phase
        logic sort_init;   // start of sort: width 1, first run, buffer A is source
        logic run_init;    // set up pointers of the next pair of runs
        logic merge_step;  // move one element from source to destination
        logic next_run;    // advance to the next pair of runs in this pass
        logic next_pass;   // double run width, swap buffers
        logic out_load;    // capture read data into the output register
    } msort_cmd_t;

    // datapath -> sequencer
    typedef struct packed {
        logic in_beat;     // input beat accepted this cycle
        logic in_last;     // tlast of the input beat
        logic width_lt_n;  // another pass is needed
        logic run_end;     // this merge step writes the final element of the run pair
        logic more_runs;   // pass continues after the current run pair
        logic out_taken;   // output beat accepted this cycle
        logic out_last;    // the output beat carries tlast
    } msort_sts_t;

endpackage

// ----- design/merge_sort_engine_core.sv -----
// ============================================================================
// merge_sort_engine_core - stable merge sort engine
// Loads signed 32-bit elements one beat per cycle until a beat with tlast;
// elements past CAPACITY are dropped and flag tuser on every result of the
// set. The set is then sorted ascending (ties keep arrival order) with
// bottom-up merge passes between two buffers, and read out in order with
// tlast on the final element. Each merge pass sets up every run pair and
// then merges it one element per cycle (the two-read-port source buffer
// feeds both heads); a pass check comes before each pass and after the
// last one. Each result beat goes through buffer read, output register
// load and handshake before the next one is read.
// Inputs are not taken while a set is sorting or being read out.
// ============================================================================
`timescale 1ns / 1ps

module merge_sort_engine_core #(
    parameter int CAPACITY = msort_pkg::CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic signed [msort_pkg::DATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                                s_tlast,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic signed [msort_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                                m_tlast,
    output logic                                m_tuser    // [0] overflow
);

    msort_pkg::msort_cmd_t cmd;
    msort_pkg::msort_sts_t sts;

    msort_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .sts     (sts),
        .cmd     (cmd)
    );

    msort_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    assign s_tready = cmd.accept_en;

`ifndef SYNTHESIS
    // loading and readout never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is pending");

    // the closing input beat stops loading
    a_last_stops_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("loading continued after final input beat");

    // the final result beat reopens loading
    a_last_out_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("engine did not return to loading after final result");
`endif

endmodule

// ----- design/msort_ctrl.sv -----
// ============================================================================
// msort_ctrl - sequencer of the merge sort engine
// Walks load, bottom-up merge passes and result readout, driving the
// datapath through a command bundle and watching its status bundle.
// ============================================================================
`timescale 1ns / 1ps

module msort_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  msort_pkg::msort_sts_t sts,
    output msort_pkg::msort_cmd_t cmd
);

    localparam logic [2:0] ST_LOAD     = 3'd0;
    localparam logic [2:0] ST_PASS_CHK = 3'd1;
    localparam logic [2:0] ST_RUN_SET  = 3'd2;
    localparam logic [2:0] ST_MERGE    = 3'd3;
    localparam logic [2:0] ST_OUT_RD   = 3'd4;
    localparam logic [2:0] ST_OUT_LD   = 3'd5;
    localparam logic [2:0] ST_OUT_WAIT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.accept_en = 1'b1;
                if (sts.in_beat && sts.in_last) begin
                    cmd.sort_init = 1'b1;
                    state_next    = ST_PASS_CHK;
                end
            end
            ST_PASS_CHK: begin
                state_next = sts.width_lt_n ? ST_RUN_SET : ST_OUT_RD;
            end
            ST_RUN_SET: begin
                cmd.run_init = 1'b1;
                state_next   = ST_MERGE;
            end
            ST_MERGE: begin
                cmd.merge_step = 1'b1;
                if (sts.run_end) begin
                    if (sts.more_runs) begin
                        cmd.next_run = 1'b1;
                        state_next   = ST_RUN_SET;
                    end else begin
                        cmd.next_pass = 1'b1;
                        state_next    = ST_PASS_CHK;
                    end
                end
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                cmd.out_load = 1'b1;
                state_next   = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (sts.out_taken) begin
                    state_next = sts.out_last ? ST_LOAD : ST_OUT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/msort_dpath.sv -----
// ============================================================================
// msort_dpath - datapath of the merge sort engine
// Ping-pong element buffers, element count, run pointers, the merge compare
// and the output register.
// ============================================================================
`timescale 1ns / 1ps

module msort_dpath #(
    parameter int CAPACITY = msort_pkg::CAPACITY_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  msort_pkg::msort_cmd_t             cmd,
    output msort_pkg::msort_sts_t             sts,
    input  logic                              s_tvalid,
    input  logic signed [msort_pkg::DATA_W-1:0] s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic signed [msort_pkg::DATA_W-1:0] m_tdata,
    output logic                              m_tlast,
    output logic                              m_tuser
);

    localparam int DW     = msort_pkg::DATA_W;
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int WID_W  = CNT_W + 1;
    localparam int SUM_W  = CNT_W + 2;

    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

    // element stores
    logic [DW-1:0] buffer_a_mem [CAPACITY];
    logic [DW-1:0] buffer_b_mem [CAPACITY];
    logic [DW-1:0] rd_a0_reg, rd_a1_reg, rd_b0_reg, rd_b1_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [WID_W-1:0] width_reg, width_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] mid_reg, mid_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             src_b_reg, src_b_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [DW-1:0]    m_tdata_reg;
    logic             m_tlast_reg;
    logic             m_tuser_reg;

    logic             in_beat, out_beat, full;
    logic [SUM_W-1:0] sum_mid, sum_hi, n_ext;
    logic [CNT_W-1:0] mid_calc, hi_calc;
    logic [DW-1:0]    head_i, head_j, merge_data;
    logic             take_left;
    logic [CNT_W-1:0] i_step, j_step;
    logic [ADDR_W-1:0] addr0, addr1, waddr;
    logic [DW-1:0]    wdata;
    logic             load_wr, wr_a, wr_b;

    assign in_beat  = s_tvalid && cmd.accept_en;
    assign out_beat = m_tvalid_reg && m_tready;
    assign full     = (count_reg >= CAP_C);

    // bounds of the current run pair, clamped to the set size
    assign n_ext    = {2'b00, count_reg};
    assign sum_mid  = {2'b00, lo_reg} + {1'b0, width_reg};
    assign sum_hi   = {2'b00, lo_reg} + {width_reg, 1'b0};
    assign mid_calc = (sum_mid > n_ext) ? count_reg : sum_mid[CNT_W-1:0];
    assign hi_calc  = (sum_hi > n_ext) ? count_reg : sum_hi[CNT_W-1:0];

    // merge compare: left run wins ties
    assign head_i     = src_b_reg ? rd_b0_reg : rd_a0_reg;
    assign head_j     = src_b_reg ? rd_b1_reg : rd_a1_reg;
    assign take_left  = (i_reg < mid_reg) &&
                        ((j_reg >= hi_reg) || ($signed(head_i) <= $signed(head_j)));
    assign merge_data = take_left ? head_i : head_j;
    assign i_step     = take_left ? i_reg + ONE_C : i_reg;
    assign j_step     = take_left ? j_reg : j_reg + ONE_C;

    // read addresses run one step ahead so heads are ready each cycle
    always_comb begin
        if (cmd.run_init) begin
            addr0 = lo_reg[ADDR_W-1:0];
            addr1 = mid_calc[ADDR_W-1:0];
        end else if (cmd.merge_step) begin
            addr0 = i_step[ADDR_W-1:0];
            addr1 = j_step[ADDR_W-1:0];
        end else begin
            addr0 = k_reg[ADDR_W-1:0];
            addr1 = k_reg[ADDR_W-1:0];
        end
    end

    // write port: load into A, merge into the destination buffer
    assign load_wr = in_beat && !full;
    assign wr_a    = load_wr || (cmd.merge_step && src_b_reg);
    assign wr_b    = cmd.merge_step && !src_b_reg;
    assign waddr   = load_wr ? count_reg[ADDR_W-1:0] : k_reg[ADDR_W-1:0];
    assign wdata   = load_wr ? $unsigned(s_tdata) : merge_data;

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            buffer_a_mem[waddr] <= wdata;
        end
        rd_a0_reg <= buffer_a_mem[addr0];
        rd_a1_reg <= buffer_a_mem[addr1];
    end

    always_ff @(posedge aclk) begin
        if (wr_b) begin
            buffer_b_mem[waddr] <= wdata;
        end
        rd_b0_reg <= buffer_b_mem[addr0];
        rd_b1_reg <= buffer_b_mem[addr1];
    end

    // pointer and count updates
    always_comb begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        width_next    = width_reg;
        lo_next       = lo_reg;
        mid_next      = mid_reg;
        hi_next       = hi_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        src_b_next    = src_b_reg;
        m_tvalid_next = m_tvalid_reg;

        if (in_beat) begin
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + ONE_C;
            end
        end
        if (cmd.sort_init) begin
            width_next = WID_W'(1);
            lo_next    = '0;
            k_next     = '0;
            src_b_next = 1'b0;
        end
        if (cmd.run_init) begin
            mid_next = mid_calc;
            hi_next  = hi_calc;
            i_next   = lo_reg;
            j_next   = mid_calc;
            k_next   = lo_reg;
        end
        if (cmd.merge_step) begin
            i_next = i_step;
            j_next = j_step;
            k_next = k_reg + ONE_C;
        end
        if (cmd.next_run) begin
            lo_next = hi_reg;
        end
        if (cmd.next_pass) begin
            width_next = {width_reg[WID_W-2:0], 1'b0};
            lo_next    = '0;
            k_next     = '0;
            src_b_next = !src_b_reg;
        end
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end
        // result beat taken: step readout, close the set after the final one
        if (out_beat) begin
            m_tvalid_next = 1'b0;
            k_next        = k_reg + ONE_C;
            if (m_tlast_reg) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            width_reg    <= '0;
            lo_reg       <= '0;
            mid_reg      <= '0;
            hi_reg       <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            src_b_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            width_reg    <= width_next;
            lo_reg       <= lo_next;
            mid_reg      <= mid_next;
            hi_reg       <= hi_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            src_b_reg    <= src_b_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= src_b_reg ? rd_b0_reg : rd_a0_reg;
            m_tlast_reg <= (k_reg + ONE_C == count_reg);
            m_tuser_reg <= ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = $signed(m_tdata_reg);
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // status to the sequencer
    assign sts.in_beat    = in_beat;
    assign sts.in_last    = s_tlast;
    assign sts.width_lt_n = (width_reg < {1'b0, count_reg});
    assign sts.run_end    = (k_reg + ONE_C == hi_reg);
    assign sts.more_runs  = (hi_reg < count_reg);
    assign sts.out_taken  = out_beat;
    assign sts.out_last   = m_tlast_reg;

endmodule
